FILE: src/tlsd_pkg.sv
// ----------------------------------------------------------------------------
// tlsd_pkg: shared types and constants for the type/length string decoder
// Holds the string type codes, the entry passed from front to back and the
// BCD-plus character table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tlsd_pkg;

	// Input item kinds.
	localparam logic KIND_HEADER = 1'b0;
	localparam logic KIND_DATA   = 1'b1;

	// String types as carried in header bits 7:6.
	typedef enum logic [1:0] {
		STR_BINARY = 2'd0,
		STR_BCD    = 2'd1,
		STR_PACK6  = 2'd2,
		STR_ASCII8 = 2'd3
	} tlsd_type_t;

	// Position within a group of three bytes that pack four 6-bit characters.
	typedef enum logic [1:0] {
		PACK_FIRST  = 2'd0,
		PACK_SECOND = 2'd1,
		PACK_THIRD  = 2'd2,
		PACK_SPARE  = 2'd3
	} tlsd_phase_t;

	localparam logic [7:0] ASCII_SPACE = 8'h20;

	localparam int unsigned QUEUE_DEPTH_DEFAULT = 2;

	// One classified data or error beat: one or two results.
	typedef struct packed {
		logic [7:0] ch0;
		logic [7:0] ch1;
		logic       two;         // second character present
		logic       char_valid0; // first result carries a character
		logic       end_last;    // the last result closes the string
		logic       err;
	} tlsd_entry_t;

	function automatic logic [7:0] bcd_char(input logic [3:0] nib);
		logic [7:0] c;
		case (nib)
			4'd0:  c = "0";
			4'd1:  c = "1";
			4'd2:  c = "2";
			4'd3:  c = "3";
			4'd4:  c = "4";
			4'd5:  c = "5";
			4'd6:  c = "6";
			4'd7:  c = "7";
			4'd8:  c = "8";
			4'd9:  c = "9";
			4'd10: c = " ";
			4'd11: c = "-";
			4'd12: c = ".";
			default: c = "X";
		endcase
		return c;
	endfunction

endpackage

`default_nettype wire

FILE: src/type_length_string_decoder.sv
// ----------------------------------------------------------------------------
// type_length_string_decoder: type/length string decoder top level
// Decodes BCD-plus, packed 6-bit and 8-bit ASCII strings that follow a
// type/length header into a stream of characters.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake            | payload
//  in       | input     | in_valid / in_ready  | kind, byte_value
//  out      | output    | out_valid/ out_ready | char_valid, character,
//           |           |                      | end_of_name, error
//
//  An input beat is classified in the cycle it is accepted and written to the
//  queue; its first result is presented once the output register loads it.
//  The output stage sends one result a cycle while out_ready is high; a beat
//  with two characters (BCD-plus, third packed byte) yields two such results.
//  The queue of QUEUE_DEPTH entries absorbs output stalls; in_ready drops only
//  when it is full. Beats that give no result never enter the queue.
//  Reset clears the string state and empties the queue; no result is pending.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module type_length_string_decoder import tlsd_pkg::*; #(
	parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic        kind,
	input  wire logic [7:0]  byte_value,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic             char_valid,
	output logic [7:0]       character,
	output logic             end_of_name,
	output logic             error
);

	tlsd_entry_t push_entry;
	tlsd_entry_t head;
	logic        push;
	logic        full;
	logic        pop;
	logic        not_empty;

	tlsd_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.kind       (kind),
		.byte_value (byte_value),
		.q_full     (full),
		.q_push     (push),
		.q_entry    (push_entry)
	);

	tlsd_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.full       (full),
		.pop        (pop),
		.not_empty  (not_empty),
		.head       (head)
	);

	tlsd_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_not_empty (not_empty),
		.q_head      (head),
		.q_pop       (pop),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.char_valid  (char_valid),
		.character   (character),
		.end_of_name (end_of_name),
		.error       (error)
	);

endmodule

`default_nettype wire

FILE: src/tlsd_front.sv
// ----------------------------------------------------------------------------
// tlsd_front: input stage of the type/length string decoder
// Accepts header and data beats, keeps the open string's state and turns
// each beat into a queue entry of zero, one or two results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tlsd_front import tlsd_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic        kind,
	input  wire logic [7:0]  byte_value,
	input  wire logic        q_full,
	output logic             q_push,
	output tlsd_entry_t      q_entry
);

	tlsd_type_t  string_type_q, string_type_d;
	logic [4:0]  bytes_left_q, bytes_left_d;
	tlsd_phase_t pack_phase_q, pack_phase_d;
	logic [3:0]  carried_q, carried_d;
	logic        term_q, term_d;
	logic        in_fire;
	logic        last;

	assign in_ready = !q_full;
	assign in_fire  = in_valid && in_ready;
	assign last     = (bytes_left_q == 5'd1);

	always_comb begin
		string_type_d = string_type_q;
		bytes_left_d  = bytes_left_q;
		pack_phase_d  = pack_phase_q;
		carried_d     = carried_q;
		term_d        = term_q;
		q_push        = 1'b0;
		q_entry       = '0;
		if (kind == KIND_HEADER) begin
			string_type_d = tlsd_type_t'(byte_value[7:6]);
			bytes_left_d  = byte_value[4:0];
			pack_phase_d  = PACK_FIRST;
			carried_d     = 4'd0;
			term_d        = 1'b0;
			if (byte_value[4:0] == 5'd0) begin
				q_push      = in_fire;
				q_entry.err = 1'b1;
			end
		end else if (bytes_left_q == 5'd0) begin
			// Data beat with no open string: error, state untouched.
			q_push      = in_fire;
			q_entry.err = 1'b1;
		end else begin
			bytes_left_d     = bytes_left_q - 5'd1;
			q_entry.end_last = last;
			unique case (string_type_q)
				STR_BCD: begin
					q_entry.ch0         = bcd_char(byte_value[7:4]);
					q_entry.ch1         = bcd_char(byte_value[3:0]);
					q_entry.two         = 1'b1;
					q_entry.char_valid0 = 1'b1;
				end
				STR_PACK6: begin
					q_entry.char_valid0 = 1'b1;
					unique case (pack_phase_q)
						PACK_FIRST: begin
							q_entry.ch0  = {2'b00, byte_value[5:0]} + ASCII_SPACE;
							carried_d    = {2'b00, byte_value[7:6]};
							pack_phase_d = PACK_SECOND;
						end
						PACK_SECOND: begin
							q_entry.ch0  = {2'b00, byte_value[3:0], carried_q[1:0]}
								+ ASCII_SPACE;
							carried_d    = byte_value[7:4];
							pack_phase_d = PACK_THIRD;
						end
						PACK_THIRD, PACK_SPARE: begin
							q_entry.ch0  = {2'b00, byte_value[1:0], carried_q}
								+ ASCII_SPACE;
							q_entry.ch1  = {2'b00, byte_value[7:2]} + ASCII_SPACE;
							q_entry.two  = 1'b1;
							carried_d    = 4'd0;
							pack_phase_d = PACK_FIRST;
						end
						default: begin
							pack_phase_d = PACK_FIRST;
						end
					endcase
				end
				STR_ASCII8: begin
					if (!term_q) begin
						if (byte_value == 8'd0) begin
							term_d = 1'b1;
						end else begin
							q_entry.ch0         = byte_value;
							q_entry.char_valid0 = 1'b1;
						end
					end
				end
				default: begin
				end
			endcase
			// A beat with no character only yields a result when it closes the string.
			q_push = in_fire && (q_entry.char_valid0 || last);
			if (last) begin
				pack_phase_d = PACK_FIRST;
				carried_d    = 4'd0;
				term_d       = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			string_type_q <= STR_BINARY;
			bytes_left_q  <= 5'd0;
			pack_phase_q  <= PACK_FIRST;
			carried_q     <= 4'd0;
			term_q        <= 1'b0;
		end else if (in_fire) begin
			string_type_q <= string_type_d;
			bytes_left_q  <= bytes_left_d;
			pack_phase_q  <= pack_phase_d;
			carried_q     <= carried_d;
			term_q        <= term_d;
		end
	end

	// A zero-length header always queues an error result.
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && kind == KIND_HEADER && byte_value[4:0] == 5'd0)
		|-> (q_push && q_entry.err))
		else $error("zero-length header did not raise an error");

	// The carried bits are empty whenever a packed group starts afresh.
	assert property (@(posedge clk) disable iff (!arst_n)
		(pack_phase_q == PACK_FIRST) |-> (carried_q == 4'd0))
		else $error("carried bits left over at group start");

endmodule

`default_nettype wire

FILE: src/tlsd_queue.sv
// ----------------------------------------------------------------------------
// tlsd_queue: entry queue between front and back
// A small circular buffer of classified entries so that the input side and
// the output side can stall independently.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tlsd_queue import tlsd_pkg::*; #(
	parameter int unsigned DEPTH = QUEUE_DEPTH_DEFAULT
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	input  tlsd_entry_t      push_entry,
	output logic             full,
	input  wire logic        pop,
	output logic             not_empty,
	output tlsd_entry_t      head
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	tlsd_entry_t      slots_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push, do_pop;

	assign full      = (count_q == CNT_W'(DEPTH));
	assign not_empty = (count_q != '0);
	assign head      = slots_q[rd_ptr_q];
	assign do_push   = push && !full;
	assign do_pop    = pop && not_empty;

	function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
	endfunction

	always_ff @(posedge clk) begin
		if (do_push) begin
			slots_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			end
			if (do_pop) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("queue occupancy beyond its depth");

	// The front never offers an entry to a full queue.
	assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("entry pushed into a full queue");

	assert property (@(posedge clk) disable iff (!arst_n)
		(do_push && !do_pop) |=> (count_q == $past(count_q) + CNT_W'(1)))
		else $error("queue occupancy did not follow a push");

endmodule

`default_nettype wire

FILE: src/tlsd_back.sv
// ----------------------------------------------------------------------------
// tlsd_back: output stage of the type/length string decoder
// Takes one entry at a time from the queue into a register and presents its
// one or two results on the output channel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tlsd_back import tlsd_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        q_not_empty,
	input  tlsd_entry_t      q_head,
	output logic             q_pop,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic             char_valid,
	output logic [7:0]       character,
	output logic             end_of_name,
	output logic             error
);

	tlsd_entry_t cur_q;
	logic        cur_valid_q;
	logic        second_q;   // presenting the second result of the entry
	logic        out_fire;
	logic        cur_done;
	logic        load;

	assign out_fire = out_valid && out_ready;
	assign cur_done = out_fire && (!cur_q.two || second_q);
	assign load     = !cur_valid_q || cur_done;
	assign q_pop    = load && q_not_empty;

	assign out_valid   = cur_valid_q;
	assign char_valid  = second_q ? 1'b1 : cur_q.char_valid0;
	assign character   = second_q ? cur_q.ch1 : cur_q.ch0;
	assign end_of_name = cur_q.end_last && (second_q || !cur_q.two);
	assign error       = cur_q.err && !second_q;

	always_ff @(posedge clk) begin
		if (q_pop) begin
			cur_q <= q_head;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
			second_q    <= 1'b0;
		end else if (load) begin
			cur_valid_q <= q_not_empty;
			second_q    <= 1'b0;
		end else if (out_fire) begin
			second_q    <= 1'b1;
		end
	end

	// The second result only exists for entries that carry two characters.
	assert property (@(posedge clk) disable iff (!arst_n)
		second_q |-> (cur_valid_q && cur_q.two))
		else $error("second result shown for a single-result entry");

	// An error result never carries a character.
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && error) |-> !char_valid)
		else $error("error result carries a character");

endmodule

`default_nettype wire
